// ===== rtl/sida_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Signed integer to decimal ASCII package
// Widths, character codes, state encoding and status types shared by the
// converter and the top level.
// ---------------------------------------------------------------------------
package sida_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int DIGITS      = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
   localparam int BCD_W       = DIGITS * 4;
   localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
   localparam int REM_W       = $clog2(DIGITS + 1);
   localparam int CHAR_W      = 6;
   localparam int COUNT_W     = 32;
   localparam int REQ_W       = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_W       = ((CHAR_W + COUNT_W + 7) / 8) * 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cvt_status_type;

endpackage

// ===== rtl/sida_dabble.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial binary to BCD converter
// Shifts the magnitude in one bit per cycle, applying the add-three
// correction to every decimal digit before each shift.
// ---------------------------------------------------------------------------
module sida_dabble (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [sida_pkg::VALUE_WIDTH-1:0]   magnitude,
   output sida_pkg::cvt_status_type           status,
   output logic [sida_pkg::BCD_W-1:0]         bcd
);

   logic [sida_pkg::VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [sida_pkg::BCD_W-1:0]       bcd_ff, bcd_in;
   logic [sida_pkg::BCD_W-1:0]       corrected;
   logic [sida_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   always_comb begin
      for (int i = 0; i < sida_pkg::DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            corrected[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            corrected[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         mag_in   = magnitude;
         bcd_in   = '0;
         count_in = sida_pkg::CNT_W'(sida_pkg::VALUE_WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         mag_in   = {mag_ff[sida_pkg::VALUE_WIDTH-2:0], 1'b0};
         bcd_in   = {corrected[sida_pkg::BCD_W-2:0], mag_ff[sida_pkg::VALUE_WIDTH-1]};
         count_in = count_ff - 1'b1;
         if (count_ff == sida_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

   // Done is reported only as busy falls, at the end of a run.
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("converter reported done without finishing a run");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != '0)
      else $error("converter busy with an exhausted bit count");

   assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && count_ff == sida_pkg::CNT_W'(sida_pkg::VALUE_WIDTH))
      else $error("converter did not load a full bit count on start");

endmodule

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Signed integer to decimal ASCII unit
// Prints each two's-complement input beat as decimal characters, one output
// beat per character, with a running character count.
// ---------------------------------------------------------------------------
// One input beat is taken at a time. Its magnitude is converted to BCD by a
// shift-and-add-three converter that takes one input bit per cycle. Leading
// zero digits are then dropped one per cycle, and characters leave one per
// cycle while the consumer accepts them, a minus sign first for a negative
// value. A new value is taken only after the last character of the previous
// one has been loaded. The last character of a number carries tlast; the
// running count wraps at 32 bits and is reset to zero.
module signed_int_to_decimal_ascii_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sida_pkg::REQ_W-1:0]      req_tdata,   // value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sida_pkg::RSP_W-1:0]      rsp_tdata,   // char_code, running_count
   output logic                            rsp_tlast
);

   sida_pkg::state_type              state_ff, state_in;
   sida_pkg::cvt_status_type         cvt_status;
   logic [sida_pkg::BCD_W-1:0]       cvt_bcd;
   logic [sida_pkg::VALUE_WIDTH-1:0] value;
   logic [sida_pkg::VALUE_WIDTH-1:0] magnitude;
   logic                             accept;
   logic                             load_ok;

   logic [sida_pkg::BCD_W-1:0]       dig_ff, dig_in;
   logic [sida_pkg::REM_W-1:0]       remaining_ff, remaining_in;
   logic                             neg_ff, neg_in;
   logic [sida_pkg::COUNT_W-1:0]     chars_ff, chars_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sida_pkg::CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [sida_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic [3:0]                       top_digit;

   assign value     = req_tdata[sida_pkg::VALUE_WIDTH-1:0];
   assign magnitude = value[sida_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;
   assign accept    = req_tvalid && req_tready;
   assign load_ok   = !rsp_valid_ff || rsp_tready;
   assign top_digit = dig_ff[sida_pkg::BCD_W-1 -: 4];

   sida_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .magnitude (magnitude),
      .status    (cvt_status),
      .bcd       (cvt_bcd)
   );

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      remaining_in = remaining_ff;
      neg_in       = neg_ff;
      chars_in     = chars_ff;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         sida_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               neg_in   = value[sida_pkg::VALUE_WIDTH-1];
               state_in = sida_pkg::ST_CONV;
            end
         end
         sida_pkg::ST_CONV: begin
            if (cvt_status.done) begin
               dig_in       = cvt_bcd;
               remaining_in = sida_pkg::REM_W'(sida_pkg::DIGITS);
               state_in     = sida_pkg::ST_SKIP;
            end
         end
         sida_pkg::ST_SKIP: begin
            if (top_digit == 4'd0 && remaining_ff > sida_pkg::REM_W'(1)) begin
               dig_in       = {dig_ff[sida_pkg::BCD_W-5:0], 4'd0};
               remaining_in = remaining_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = sida_pkg::ST_SIGN;
            end else begin
               state_in = sida_pkg::ST_DIGIT;
            end
         end
         sida_pkg::ST_SIGN: begin
            if (load_ok) begin
               chars_in     = chars_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = sida_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_count_in = chars_ff + 1'b1;
               state_in     = sida_pkg::ST_DIGIT;
            end
         end
         sida_pkg::ST_DIGIT: begin
            if (load_ok) begin
               chars_in     = chars_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = sida_pkg::CHAR_ZERO + {2'b00, top_digit};
               rsp_last_in  = (remaining_ff == sida_pkg::REM_W'(1));
               rsp_count_in = chars_ff + 1'b1;
               dig_in       = {dig_ff[sida_pkg::BCD_W-5:0], 4'd0};
               remaining_in = remaining_ff - 1'b1;
               if (remaining_ff == sida_pkg::REM_W'(1)) begin
                  state_in = sida_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sida_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sida_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff       <= dig_in;
      remaining_ff <= remaining_in;
      neg_ff       <= neg_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         chars_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chars_ff     <= chars_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(sida_pkg::RSP_W - sida_pkg::CHAR_W - sida_pkg::COUNT_W){1'b0}},
                        rsp_count_ff, rsp_char_ff};

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_char_ff == sida_pkg::CHAR_MINUS ||
                       (rsp_char_ff >= sida_pkg::CHAR_ZERO &&
                        rsp_char_ff <= sida_pkg::CHAR_ZERO + 6'd9))
      else $error("output beat holds a character that is neither digit nor minus");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == sida_pkg::ST_DIGIT |-> remaining_ff != '0)
      else $error("digit emission with no digits remaining");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == sida_pkg::ST_SIGN |-> neg_ff)
      else $error("minus sign emitted for a non-negative value");

   assert property (@(posedge clock) disable iff (reset)
      cvt_status.done |-> state_ff == sida_pkg::ST_CONV)
      else $error("conversion finished outside the conversion state");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff && rsp_char_ff == sida_pkg::CHAR_MINUS |-> 1'b0)
      else $error("a number ended on its minus sign");

endmodule
